@@ design/bdf_pkg.sv @@
// Shared types and constants for the boost duty feed-forward controller.
// Used by bdf_ctrl, bdf_dpath and the top level; no dependencies.
`default_nettype none

package bdf_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int DUTY_W    = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 20;   // cycle_period * vin_nominal

    // Stream payload widths
    localparam int S_DATA_W = 16;    // sample, output_enable
    localparam int S_USER_W = 2;     // req_type, channel
    localparam int M_DATA_W = 40;    // drive_mode, duty, pwm_load, vin_avg, vout_avg

    // Item kinds and channels
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic CH_VOUT    = 1'b0;
    localparam logic CH_VIN     = 1'b1;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PWM  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIN_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIN_NOMINAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd4;

    // Reset values
    localparam logic [SAMPLE_W-1:0] RST_VIN_THRESHOLD = 12'd1631;
    localparam logic [DUTY_W-1:0]   RST_CYCLE_PERIOD  = 8'd200;
    localparam logic [SAMPLE_W-1:0] RST_VIN_NOMINAL   = 12'd1474;
    localparam logic [DUTY_W-1:0]   RST_MIN_DUTY      = 8'd154;
    localparam logic [DUTY_W-1:0]   RST_MAX_DUTY      = 8'd180;
    localparam logic [DUTY_W-1:0]   RST_DUTY          = 8'd180;
    localparam logic [DUTY_W-1:0]   DUTY_SAT          = 8'd255;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic apply;
        logic out_load;
    } bdf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic need_scale;
    } bdf_status_t;

endpackage

`default_nettype wire

@@ design/bdf_ctrl.sv @@
// Sequencer for the boost duty controller: item acceptance, divider
// iteration count and output beat handshake. Depends on bdf_pkg.
`default_nettype none

module bdf_ctrl #(
    parameter int DIV_W = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire bdf_pkg::bdf_status_t status,
    output bdf_pkg::bdf_cmd_t         cmd
);
    import bdf_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_APPLY,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                step_next = '0;
                if (status.need_div)
                    state_next = ST_DIV;
                else if (status.need_scale)
                    state_next = ST_APPLY;
                else
                    state_next = ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/bdf_dpath.sv @@
// Datapath for the boost duty controller: configuration registers, block
// averagers, feed-forward divider and duty stepping. Depends on bdf_pkg.
`default_nettype none

module bdf_dpath #(
    parameter int AVG_COUNT = 100
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bdf_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             in_req_type,
    input  wire logic                             in_channel,
    input  wire logic [bdf_pkg::SAMPLE_W-1:0]     in_sample,
    input  wire logic                             in_output_enable,
    input  wire bdf_pkg::bdf_cmd_t                cmd,
    output bdf_pkg::bdf_status_t                  status,
    output logic [bdf_pkg::MODE_W-1:0]            drive_mode,
    output logic [bdf_pkg::DUTY_W-1:0]            duty,
    output logic                                  pwm_load,
    output logic [bdf_pkg::SAMPLE_W-1:0]          vin_avg,
    output logic [bdf_pkg::SAMPLE_W-1:0]          vout_avg
);
    import bdf_pkg::*;

    localparam int SUM_W  = $clog2(AVG_COUNT * 4095 + 1);
    localparam int CNT_W  = $clog2(AVG_COUNT + 1);
    localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DEN_W  = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

    // block mean by reciprocal: ceil(2^(SUM_W+l) / AVG_COUNT), exact for any block sum
    localparam int REC_L   = $clog2(AVG_COUNT);
    localparam int REC_S   = SUM_W + REC_L;
    localparam int REC_W   = SUM_W + 2;
    localparam int MPROD_W = SUM_W + REC_W;
    localparam longint unsigned REC_M =
        ((64'd1 << REC_S) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);

    // configuration
    logic [SAMPLE_W-1:0] vin_threshold_reg;
    logic [DUTY_W-1:0]   cycle_period_reg;
    logic [SAMPLE_W-1:0] vin_nominal_reg;
    logic [DUTY_W-1:0]   min_duty_reg;
    logic [DUTY_W-1:0]   max_duty_reg;

    // controller state
    logic [SUM_W-1:0]    vin_sum_reg, vin_sum_next, vout_sum_reg, vout_sum_next;
    logic [CNT_W-1:0]    vin_cnt_reg, vin_cnt_next, vout_cnt_reg, vout_cnt_next;
    logic [SAMPLE_W-1:0] vin_mean_reg, vin_mean_next, vout_mean_reg, vout_mean_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                load_reg, load_next;

    // captured item and divider, no reset needed
    logic                req_reg, chan_reg, en_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    rem_reg, rem_next, den_reg, den_next;

    // output payload
    logic [MODE_W-1:0]   out_mode_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic                out_load_reg;
    logic [SAMPLE_W-1:0] out_vin_reg, out_vout_reg;

    // combinational helpers
    logic [SUM_W-1:0]    acc_sum;
    logic [CNT_W-1:0]    acc_cnt;
    logic                acc_wrap;
    logic                vin_low;
    logic                vin_zero;
    logic [PROD_W-1:0]   prod;
    logic [DEN_W:0]      rem_sh, rem_diff;
    logic [MPROD_W-1:0]  mean_prod;
    logic [SAMPLE_W-1:0] mean_q;
    logic [DUTY_W-1:0]   q_sat, tgt_base, tgt;
    logic [DUTY_W-1:0]   step_duty;
    logic [MODE_W-1:0]   step_mode;
    logic                step_load;

    assign acc_sum  = ((chan_reg == CH_VIN) ? vin_sum_reg : vout_sum_reg)
                      + SUM_W'(sample_reg);
    assign acc_cnt  = ((chan_reg == CH_VIN) ? vin_cnt_reg : vout_cnt_reg) + 1'b1;
    assign acc_wrap = (acc_cnt == CNT_W'(AVG_COUNT));
    assign vin_low  = (vin_mean_reg < vin_threshold_reg);
    assign vin_zero = (vin_mean_reg == '0);
    assign prod     = PROD_W'(cycle_period_reg) * PROD_W'(vin_nominal_reg);

    assign status.need_div   = (req_reg == REQ_TICK) && en_reg && !vin_low && !vin_zero;
    assign status.need_scale = (req_reg == REQ_SAMPLE) && acc_wrap;

    // block sum is parked in quo_reg between eval and apply
    assign mean_prod = MPROD_W'(quo_reg[SUM_W-1:0]) * MPROD_W'(REC_M);
    assign mean_q    = mean_prod[REC_S +: SAMPLE_W];

    // one restoring division step
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    // feed-forward target: saturate at full scale, raise to min_duty
    assign q_sat    = (|quo_reg[DIV_W-1:DUTY_W]) ? DUTY_SAT : quo_reg[DUTY_W-1:0];
    assign tgt_base = vin_zero ? DUTY_SAT : q_sat;
    assign tgt      = (tgt_base < min_duty_reg) ? min_duty_reg : tgt_base;

    always_comb
    begin
        step_duty = duty_reg;
        step_mode = mode_reg;
        step_load = 1'b0;
        if (duty_reg != tgt)
        begin
            step_duty = (duty_reg > tgt) ? duty_reg - 1'b1 : duty_reg + 1'b1;
            step_mode = MODE_PWM;
            step_load = 1'b1;
        end
        else if (mode_reg != MODE_PWM)
        begin
            step_mode = MODE_PWM;
            step_load = 1'b1;
        end
    end

    always_comb
    begin
        vin_sum_next   = vin_sum_reg;
        vout_sum_next  = vout_sum_reg;
        vin_cnt_next   = vin_cnt_reg;
        vout_cnt_next  = vout_cnt_reg;
        vin_mean_next  = vin_mean_reg;
        vout_mean_next = vout_mean_reg;
        duty_next      = duty_reg;
        mode_next      = mode_reg;
        load_next      = load_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;

        if (cmd.eval)
        begin
            load_next = 1'b0;
            if (req_reg == REQ_SAMPLE)
            begin
                if (acc_wrap)
                    quo_next = DIV_W'(acc_sum);
                if (chan_reg == CH_VIN)
                begin
                    vin_sum_next = acc_wrap ? '0 : acc_sum;
                    vin_cnt_next = acc_wrap ? '0 : acc_cnt;
                end
                else
                begin
                    vout_sum_next = acc_wrap ? '0 : acc_sum;
                    vout_cnt_next = acc_wrap ? '0 : acc_cnt;
                end
            end
            else if (!en_reg)
            begin
                if (mode_reg != MODE_OFF)
                begin
                    mode_next = MODE_OFF;
                    load_next = 1'b1;
                end
            end
            else if (vin_low)
            begin
                if (mode_reg != MODE_FULL)
                begin
                    mode_next = MODE_FULL;
                    duty_next = max_duty_reg;
                    load_next = 1'b1;
                end
            end
            else if (!vin_zero)
            begin
                quo_next = DIV_W'(prod);
                den_next = DEN_W'(vin_mean_reg);
                rem_next = '0;
            end
            else
            begin
                duty_next = step_duty;
                mode_next = step_mode;
                load_next = step_load;
            end
        end

        if (cmd.div_step)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ~rem_diff[DEN_W]};
            rem_next = rem_diff[DEN_W] ? rem_sh[DEN_W-1:0] : rem_diff[DEN_W-1:0];
        end

        if (cmd.apply)
        begin
            if (req_reg == REQ_SAMPLE)
            begin
                // mean of a full block always fits the sample width
                if (chan_reg == CH_VIN)
                    vin_mean_next = mean_q;
                else
                    vout_mean_next = mean_q;
            end
            else
            begin
                duty_next = step_duty;
                mode_next = step_mode;
                load_next = step_load;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_threshold_reg <= RST_VIN_THRESHOLD;
            cycle_period_reg  <= RST_CYCLE_PERIOD;
            vin_nominal_reg   <= RST_VIN_NOMINAL;
            min_duty_reg      <= RST_MIN_DUTY;
            max_duty_reg      <= RST_MAX_DUTY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VIN_THRESHOLD: vin_threshold_reg <= cfg_data;
                REG_CYCLE_PERIOD:  cycle_period_reg  <= cfg_data[DUTY_W-1:0];
                REG_VIN_NOMINAL:   vin_nominal_reg   <= cfg_data;
                REG_MIN_DUTY:      min_duty_reg      <= cfg_data[DUTY_W-1:0];
                REG_MAX_DUTY:      max_duty_reg      <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_sum_reg   <= '0;
            vout_sum_reg  <= '0;
            vin_cnt_reg   <= '0;
            vout_cnt_reg  <= '0;
            vin_mean_reg  <= '0;
            vout_mean_reg <= '0;
            duty_reg      <= RST_DUTY;
            mode_reg      <= MODE_NONE;
            load_reg      <= 1'b0;
        end
        else
        begin
            vin_sum_reg   <= vin_sum_next;
            vout_sum_reg  <= vout_sum_next;
            vin_cnt_reg   <= vin_cnt_next;
            vout_cnt_reg  <= vout_cnt_next;
            vin_mean_reg  <= vin_mean_next;
            vout_mean_reg <= vout_mean_next;
            duty_reg      <= duty_next;
            mode_reg      <= mode_next;
            load_reg      <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg    <= in_req_type;
            chan_reg   <= in_channel;
            sample_reg <= in_sample;
            en_reg     <= in_output_enable;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (cmd.out_load)
        begin
            out_mode_reg <= mode_reg;
            out_duty_reg <= duty_reg;
            out_load_reg <= load_reg;
            out_vin_reg  <= vin_mean_reg;
            out_vout_reg <= vout_mean_reg;
        end
    end

    assign drive_mode = out_mode_reg;
    assign duty       = out_duty_reg;
    assign pwm_load   = out_load_reg;
    assign vin_avg    = out_vin_reg;
    assign vout_avg   = out_vout_reg;

endmodule

`default_nettype wire

@@ design/boost_duty_feedforward_controller.sv @@
// Top level of the boost duty feed-forward controller: stream ports,
// configuration port and packing. Depends on bdf_pkg, bdf_ctrl, bdf_dpath.
//
// One beat in gives one beat out. Sample beats add into the channel's block
// sum; every AVG_COUNT samples the sum is scaled by a fixed reciprocal of
// AVG_COUNT to give the averaged code. Control ticks pick the drive mode and,
// in PWM mode, step the duty one count toward cycle_period * vin_nominal /
// vin_avg. That quotient comes from a restoring divider, one quotient bit per
// cycle, with DIV_W = max(20, bits of AVG_COUNT*4095) quotient bits (20 at
// the default). A tick that needs the divider goes through capture, eval,
// the divider steps, apply and the output load; a sample that closes a block
// skips the divider, and any other beat also skips apply. Items are handled
// one at a time; the result sits in an output register, so a new beat can be
// taken while the previous result waits for m_tready, and only a result still
// held when the next one is ready holds the block back. Configuration writes
// are taken at any time and should only be made while the block is idle.
`default_nettype none

module boost_duty_feedforward_controller #(
    parameter int AVG_COUNT = 100
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bdf_pkg::S_DATA_W-1:0]      s_tdata,  // sample[11:0], output_enable[12]
    input  wire logic [bdf_pkg::S_USER_W-1:0]      s_tuser,  // req_type[0], channel[1]
    // master side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // drive_mode[1:0], duty[9:2], pwm_load[10], vin_avg[22:11], vout_avg[34:23]
    output logic [bdf_pkg::M_DATA_W-1:0]           m_tdata,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [bdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bdf_pkg::CFG_W-1:0]         cfg_data
);
    import bdf_pkg::*;

    localparam int SUM_W = $clog2(AVG_COUNT * 4095 + 1);
    localparam int DIV_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int OUT_W = MODE_W + DUTY_W + 1 + 2 * SAMPLE_W;

    bdf_cmd_t            cmd;
    bdf_status_t         status;
    logic [MODE_W-1:0]   drive_mode;
    logic [DUTY_W-1:0]   duty;
    logic                pwm_load;
    logic [SAMPLE_W-1:0] vin_avg, vout_avg;

    bdf_ctrl #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdf_dpath #(
        .AVG_COUNT (AVG_COUNT)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_req_type      (s_tuser[0]),
        .in_channel       (s_tuser[1]),
        .in_sample        (s_tdata[SAMPLE_W-1:0]),
        .in_output_enable (s_tdata[SAMPLE_W]),
        .cmd              (cmd),
        .status           (status),
        .drive_mode       (drive_mode),
        .duty             (duty),
        .pwm_load         (pwm_load),
        .vin_avg          (vin_avg),
        .vout_avg         (vout_avg)
    );

    assign m_tdata = {{(M_DATA_W - OUT_W){1'b0}}, vout_avg, vin_avg, pwm_load, duty, drive_mode};

endmodule

`default_nettype wire

@@ tb/boost_duty_feedforward_controller_tb.sv @@
// Self-checking bench for boost_duty_feedforward_controller: directed and random beats
// against an in-bench model of averaging, mode choice and duty stepping.
// Depends on bdf_pkg and the design; no files, no arguments.
module boost_duty_feedforward_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdf_pkg::*;

    localparam int AVG_N       = 100;
    localparam int SETTLE_CYC  = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_BEATS = 500;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [DUTY_W-1:0]   duty;
        logic                load;
        logic [SAMPLE_W-1:0] vin;
        logic [SAMPLE_W-1:0] vout;
    } drive_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // model copy of registers and state
    logic [SAMPLE_W-1:0] thr_reg, nom_reg;
    logic [DUTY_W-1:0]   per_reg, min_reg, max_reg;
    int unsigned         acc_sum [2];
    int unsigned         acc_cnt [2];
    logic [SAMPLE_W-1:0] mean_code [2];
    logic [DUTY_W-1:0]   duty_cur;
    logic [MODE_W-1:0]   mode_cur;

    drive_result_t due_q [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int errors        = 0;
    int n_checked     = 0;
    int n_samples     = 0;
    int n_ticks       = 0;
    int n_loads       = 0;
    int quiet_cycles  = 0;

    boost_duty_feedforward_controller #(.AVG_COUNT(AVG_N)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void model_reset();
        thr_reg  = RST_VIN_THRESHOLD;
        per_reg  = RST_CYCLE_PERIOD;
        nom_reg  = RST_VIN_NOMINAL;
        min_reg  = RST_MIN_DUTY;
        max_reg  = RST_MAX_DUTY;
        for (int c = 0; c < 2; c++)
        begin
            acc_sum[c]   = 0;
            acc_cnt[c]   = 0;
            mean_code[c] = '0;
        end
        duty_cur = RST_DUTY;
        mode_cur = MODE_NONE;
    endfunction

    function automatic drive_result_t next_drive(logic req, logic chan,
                                                 logic [SAMPLE_W-1:0] smp, logic en);
        drive_result_t r;
        int unsigned   tgt;
        logic          load;
        load = 1'b0;
        if (req == REQ_SAMPLE)
        begin
            acc_sum[chan] += smp;
            acc_cnt[chan] += 1;
            if (acc_cnt[chan] >= AVG_N)
            begin
                mean_code[chan] = acc_sum[chan] / AVG_N;
                acc_sum[chan]   = 0;
                acc_cnt[chan]   = 0;
            end
        end
        else if (!en)
        begin
            if (mode_cur != MODE_OFF)
            begin
                mode_cur = MODE_OFF;
                load     = 1'b1;
            end
        end
        else if (mean_code[CH_VIN] < thr_reg)
        begin
            if (mode_cur != MODE_FULL)
            begin
                mode_cur = MODE_FULL;
                duty_cur = max_reg;
                load     = 1'b1;
            end
        end
        else
        begin
            // feedforward target, saturated quotient when the input mean is zero
            if (mean_code[CH_VIN] == 0)
                tgt = 255;
            else
                tgt = (per_reg * nom_reg) / mean_code[CH_VIN];
            if (tgt < min_reg)
                tgt = min_reg;
            if (tgt > 255)
                tgt = 255;
            if (duty_cur != tgt)
            begin
                if (duty_cur > tgt)
                    duty_cur = duty_cur - 1'b1;
                else
                    duty_cur = duty_cur + 1'b1;
                mode_cur = MODE_PWM;
                load     = 1'b1;
            end
            else if (mode_cur != MODE_PWM)
            begin
                mode_cur = MODE_PWM;
                load     = 1'b1;
            end
        end
        r.mode = mode_cur;
        r.duty = duty_cur;
        r.load = load;
        r.vin  = mean_code[CH_VIN];
        r.vout = mean_code[CH_VOUT];
        return r;
    endfunction

    task automatic send_beat(input logic req, input logic chan,
                             input logic [SAMPLE_W-1:0] smp, input logic en);
        int gap;
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {chan, req};
        s_tdata  <= {3'b000, en, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_q.push_back(next_drive(req, chan, smp, en));
        if (req == REQ_SAMPLE)
            n_samples++;
        else
            n_ticks++;
    endtask

    // stop sending and wait for the block to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_VIN_THRESHOLD: thr_reg = val;
            REG_CYCLE_PERIOD:  per_reg = val[DUTY_W-1:0];
            REG_VIN_NOMINAL:   nom_reg = val;
            REG_MIN_DUTY:      min_reg = val[DUTY_W-1:0];
            REG_MAX_DUTY:      max_reg = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // 8-bit registers get junk in the unused top nibble
    task automatic load_settings(input logic [11:0] thr, input logic [7:0] per,
                                 input logic [11:0] nom, input logic [7:0] mn,
                                 input logic [7:0] mx);
        write_reg(REG_VIN_THRESHOLD, thr);
        write_reg(REG_CYCLE_PERIOD, {4'($urandom_range(15)), per});
        write_reg(REG_VIN_NOMINAL, nom);
        write_reg(REG_MIN_DUTY, {4'($urandom_range(15)), mn});
        write_reg(REG_MAX_DUTY, {4'($urandom_range(15)), mx});
        write_reg(3'($urandom_range(5, 7)), 12'($urandom_range(4095)));
    endtask

    // Mostly blocks of samples clustered round a centre so the means land
    // where the modes change; ticks in between let the duty walk.
    task automatic run_stream(input int beats, input int idle, input int stall,
                              input bit hold_mid);
        logic [SAMPLE_W-1:0] centre [2];
        int                  jitter [2];
        int                  v;
        logic                ch;
        snd_idle_pct  = idle;
        rcv_stall_pct = stall;
        centre[0] = 12'($urandom_range(4095));
        centre[1] = thr_reg;
        jitter[0] = 20;
        jitter[1] = 20;
        for (int i = 0; i < beats; i++)
        begin
            if (hold_mid && i == beats / 2)
                settle();
            if ($urandom_range(99) < 75)
            begin
                ch = 1'($urandom_range(1));
                if (acc_cnt[ch] == 0)
                begin
                    case ($urandom_range(5))
                        0: centre[ch] = 12'd0;
                        1: centre[ch] = 12'hFFF;
                        2: centre[ch] = 12'(thr_reg + $urandom_range(40) - 20);
                        default: centre[ch] = 12'($urandom_range(4095));
                    endcase
                    jitter[ch] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 60);
                end
                if ($urandom_range(9) == 0)
                    v = $urandom_range(4095);
                else
                    v = int'(centre[ch]) + $urandom_range(2 * jitter[ch]) - jitter[ch];
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                send_beat(REQ_SAMPLE, ch, 12'(v), 1'($urandom_range(1)));
            end
            else
                send_beat(REQ_TICK, 1'($urandom_range(1)), 12'($urandom_range(4095)),
                          1'($urandom_range(99) < 85));
        end
    endtask

    task automatic test_power_up();
        send_beat(REQ_TICK, CH_VOUT, 12'h000, 1'b0);
        send_beat(REQ_TICK, CH_VIN, 12'hFFF, 1'b0);
        send_beat(REQ_TICK, CH_VOUT, 12'h000, 1'b1);
        send_beat(REQ_TICK, CH_VIN, 12'hFFF, 1'b1);
        send_beat(REQ_SAMPLE, CH_VOUT, 12'hFFF, 1'b0);
        send_beat(REQ_SAMPLE, CH_VIN, 12'h000, 1'b1);
        send_beat(REQ_TICK, CH_VOUT, 12'hFFF, 1'b1);
    endtask

    // threshold at zero lets PWM run with a zero input mean
    task automatic test_vin_zero_pwm();
        settle();
        write_reg(REG_VIN_THRESHOLD, 12'd0);
        repeat (3) send_beat(REQ_TICK, CH_VOUT, 12'hFFF, 1'b1);
        send_beat(REQ_TICK, CH_VOUT, 12'h000, 1'b0);
        send_beat(REQ_TICK, CH_VOUT, 12'h000, 1'b1);
    endtask

    task automatic test_unmapped_regs();
        settle();
        for (int k = 5; k < 8; k++)
            write_reg(3'(k), 12'hFFF);
        send_beat(REQ_TICK, CH_VIN, 12'h000, 1'b1);
        send_beat(REQ_TICK, CH_VIN, 12'h000, 1'b1);
    endtask

    task automatic test_default_regulation();
        settle();
        load_settings(RST_VIN_THRESHOLD, RST_CYCLE_PERIOD, RST_VIN_NOMINAL,
                      RST_MIN_DUTY, RST_MAX_DUTY);
        run_stream(PHASE_BEATS, 0, 0, 1'b0);
    endtask

    task automatic test_full_scale();
        settle();
        load_settings(12'hFFF, 8'd255, 12'hFFF, 8'd0, 8'd255);
        run_stream(PHASE_BEATS, 46, 0, 1'b1);
    endtask

    task automatic test_zero_period();
        settle();
        load_settings(12'd0, 8'd0, 12'hFFF, 8'd100, 8'd0);
        run_stream(PHASE_BEATS, 0, 46, 1'b0);
    endtask

    task automatic test_random_settings();
        settle();
        load_settings(12'($urandom_range(800, 3000)), 8'($urandom_range(255)),
                      12'($urandom_range(4095)), 8'($urandom_range(200)),
                      8'($urandom_range(255)));
        run_stream(PHASE_BEATS, 28, 28, 1'b0);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = due_q.pop_front();
                check_field("drive_mode", want.mode, m_tdata[1:0]);
                check_field("duty", want.duty, m_tdata[9:2]);
                check_field("pwm_load", want.load, m_tdata[10]);
                check_field("vin_avg", want.vin, m_tdata[22:11]);
                check_field("vout_avg", want.vout, m_tdata[34:23]);
                n_checked++;
                n_loads += want.load;
            end
        end
    end

    // watchdog: cycles with no beat on either side and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_up();
        test_vin_zero_pwm();
        test_unmapped_regs();
        test_default_regulation();
        test_full_scale();
        test_zero_period();
        test_random_settings();
        settle();
        $display("Checked %0d result beats: %0d samples, %0d ticks, %0d drive reloads,",
                 n_checked, n_samples, n_ticks, n_loads);
        $display("over four register settings and four idle/stall mixes.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
